// ----- rtl/core/fpbs_pkg.sv -----
// ============================================================================
// fpbs_pkg: flux PLL bit separator shared definitions
// Widths, register indexes, request codes and the sequencer control store.
// ============================================================================
`default_nettype none

package fpbs_pkg;

    localparam int TIME_BITS      = 29;
    localparam int PERIOD_BITS    = 16;
    localparam int EDGE_BITS      = 28;
    localparam int COUNT_BITS     = 28;
    localparam int BYTES_BITS     = 26;
    localparam int NOMINAL_BITS   = 16;
    localparam int CFG_DATA_BITS  = 28;
    localparam int CFG_INDEX_BITS = 1;
    localparam int DIV_CNT_BITS   = $clog2(TIME_BITS + 1);
    localparam int STEP_BITS      = 4;

    localparam logic [NOMINAL_BITS-1:0] NOMINAL_RESET  = NOMINAL_BITS'(2000);
    localparam logic [EDGE_BITS-1:0]    REV_RESET      = EDGE_BITS'(200000000);
    localparam logic [PERIOD_BITS-1:0]  PERIOD_MAX     = {PERIOD_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0]   COUNT_MAX      = {COUNT_BITS{1'b1}};

    localparam logic [CFG_INDEX_BITS-1:0] CFG_NOMINAL_PERIOD  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REVOLUTION_TIME = 1'b1;

    typedef enum logic [1:0] {
        REQ_START = 2'd0,
        REQ_EDGE  = 2'd1,
        REQ_END   = 2'd2
    } req_t;

    typedef logic [STEP_BITS-1:0] step_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_FETCH,
        ACT_ZERO,
        ACT_DIV1,
        ACT_CAPT1,
        ACT_DIV2,
        ACT_CAPT2,
        ACT_PREP,
        ACT_COMMIT,
        ACT_EMIT,
        ACT_START
    } act_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_ITEM,
        COND_IGNORE,
        COND_START,
        COND_DROP,
        COND_DIV_DONE,
        COND_NO_RESULT,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        logic  hold;
        step_t target;
    } ctrl_word_t;

    localparam step_t ST_FETCH    = STEP_BITS'(0);
    localparam step_t ST_IGNORE   = STEP_BITS'(1);
    localparam step_t ST_DISPATCH = STEP_BITS'(2);
    localparam step_t ST_DROP     = STEP_BITS'(3);
    localparam step_t ST_DIV1     = STEP_BITS'(4);
    localparam step_t ST_WAIT1    = STEP_BITS'(5);
    localparam step_t ST_DIV2     = STEP_BITS'(6);
    localparam step_t ST_WAIT2    = STEP_BITS'(7);
    localparam step_t ST_PREP     = STEP_BITS'(8);
    localparam step_t ST_COMMIT   = STEP_BITS'(9);
    localparam step_t ST_EMIT     = STEP_BITS'(10);
    localparam step_t ST_START    = STEP_BITS'(11);

    // control store: taken cond jumps to target, else hold or fall through
    function automatic ctrl_word_t ucode_word(input step_t s);
        ctrl_word_t cw;
        unique case (s)
            ST_FETCH:    cw = '{ACT_FETCH,  COND_ITEM,      1'b1, ST_IGNORE};
            ST_IGNORE:   cw = '{ACT_NONE,   COND_IGNORE,    1'b0, ST_FETCH};
            ST_DISPATCH: cw = '{ACT_NONE,   COND_START,     1'b0, ST_START};
            ST_DROP:     cw = '{ACT_ZERO,   COND_DROP,      1'b0, ST_EMIT};
            ST_DIV1:     cw = '{ACT_DIV1,   COND_NEVER,     1'b0, ST_FETCH};
            ST_WAIT1:    cw = '{ACT_CAPT1,  COND_DIV_DONE,  1'b1, ST_DIV2};
            ST_DIV2:     cw = '{ACT_DIV2,   COND_NEVER,     1'b0, ST_FETCH};
            ST_WAIT2:    cw = '{ACT_CAPT2,  COND_DIV_DONE,  1'b1, ST_PREP};
            ST_PREP:     cw = '{ACT_PREP,   COND_NEVER,     1'b0, ST_FETCH};
            ST_COMMIT:   cw = '{ACT_COMMIT, COND_NO_RESULT, 1'b0, ST_FETCH};
            ST_EMIT:     cw = '{ACT_EMIT,   COND_OUT_FREE,  1'b1, ST_FETCH};
            ST_START:    cw = '{ACT_START,  COND_ALWAYS,    1'b0, ST_FETCH};
            default:     cw = '{ACT_NONE,   COND_ALWAYS,    1'b0, ST_FETCH};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fpbs_div.sv -----
// ============================================================================
// fpbs_div: iterative restoring divider
// One quotient bit per cycle; quotient and remainder valid with done.
// ============================================================================
`default_nettype none

module fpbs_div
    import fpbs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [TIME_BITS-1:0]   dividend,
    input  wire logic [PERIOD_BITS-1:0] divisor,
    output logic      [TIME_BITS-1:0]   quotient,
    output logic      [PERIOD_BITS-1:0] remainder,
    output logic                        done
);

    logic [TIME_BITS-1:0]    quo_reg, quo_next;
    logic [PERIOD_BITS-1:0]  rem_reg, rem_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic [PERIOD_BITS:0]    shifted;
    logic [PERIOD_BITS:0]    diff;
    logic                    fits;

    assign shifted = {rem_reg, quo_reg[TIME_BITS-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign fits    = shifted >= {1'b0, divisor};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_BITS'(TIME_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[TIME_BITS-2:0], fits};
            rem_next = fits ? diff[PERIOD_BITS-1:0] : shifted[PERIOD_BITS-1:0];
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

// ----- rtl/core/flux_pll_bit_separator_top.sv -----
// ============================================================================
// flux_pll_bit_separator_top: digital PLL data separator
// Recovers zero runs between one bits from flux edge times with an adaptive
// bit-cell period; a microcoded sequencer drives a shared divider.
// ============================================================================
//  channel  beat                                  handshake
//  item     req_type, edge_time                   item_valid / item_ready
//  result   zero_run, track_bytes, track_end      result_valid / result_ready
//  cfg      cfg_index, cfg_data                   cfg_valid / cfg_ready
//
//  Edge or end beat: two passes of the one-bit-per-cycle divider (window
//  count and revolution count). Start beats, dropped edges, unknown
//  requests and an end beat after the revolution is over skip the divider.
//  One beat in flight; the next item is taken while a result waits in the
//  output register, and the sequencer stalls at emit until it drains.
//  Reset: asynchronous; period 2000 ns, revolution 200000000 ns, no clear pass.
// ============================================================================
`default_nettype none

module flux_pll_bit_separator_top
    import fpbs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output logic                           item_ready,
    input  wire logic [1:0]                req_type,
    input  wire logic [EDGE_BITS-1:0]      edge_time,
    output logic                           result_valid,
    input  wire logic                      result_ready,
    output logic      [EDGE_BITS-1:0]      zero_run,
    output logic      [BYTES_BITS-1:0]     track_bytes,
    output logic                           track_end,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int TB = TIME_BITS;
    localparam int PB = PERIOD_BITS;

    step_t                   step_reg, step_next;
    ctrl_word_t              ctrl;
    logic                    cond_met;

    logic [NOMINAL_BITS-1:0] nominal_reg;
    logic [EDGE_BITS-1:0]    rev_reg;
    logic [TB-1:0]           phase_reg;
    logic [PB-1:0]           period_reg;
    logic [COUNT_BITS-1:0]   bits_reg;

    logic [1:0]              req_reg;
    logic [EDGE_BITS-1:0]    e_reg;
    logic [TB-1:0]           k1_reg, k2_reg;
    logic [PB-1:0]           r1_reg, r2_reg;
    logic                    over_reg, over_next;
    logic [PB-1:0]           newp_reg, newp_next;
    logic [TB-1:0]           phase_cand_reg, phase_cand_next;
    logic [TB:0]             add_cnt_reg, add_cnt_next;
    logic [TB-1:0]           zeros_reg;

    logic                    result_valid_reg;
    logic [EDGE_BITS-1:0]    zero_run_reg;
    logic [BYTES_BITS-1:0]   track_bytes_reg;
    logic                    track_end_reg;

    logic [TB-1:0]           e_ext, rev_ext, p_ext, r1_ext, r2_ext;
    logic                    e_gt, drop, out_free, emit_fire;
    logic [TB-1:0]           n1, n2, phase_mid;
    logic                    div_start, div_done;
    logic [TB-1:0]           div_dividend, div_quo;
    logic [PB-1:0]           div_rem;

    logic [PB:0]             off;
    logic [PB-1:0]           half;
    logic signed [PB+1:0]    delta, delta_half, newp_raw;
    logic [TB+1:0]           bits_sum;
    logic [COUNT_BITS-1:0]   bits_sat;
    logic [COUNT_BITS:0]     bytes_sum;
    logic [PB-1:0]           start_period;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign ctrl = ucode_word(step_reg);

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:     cond_met = 1'b0;
            COND_ALWAYS:    cond_met = 1'b1;
            COND_ITEM:      cond_met = item_valid;
            COND_IGNORE:    cond_met = (req_reg != REQ_START && req_reg != REQ_EDGE &&
                                        req_reg != REQ_END) ||
                                       (req_reg == REQ_EDGE && drop);
            COND_START:     cond_met = req_reg == REQ_START;
            COND_DROP:      cond_met = drop;
            COND_DIV_DONE:  cond_met = div_done;
            COND_NO_RESULT: cond_met = req_reg == REQ_EDGE && over_reg;
            COND_OUT_FREE:  cond_met = out_free;
            default:        cond_met = 1'b1;
        endcase
    end

    always_comb
    begin
        if (cond_met)
            step_next = ctrl.target;
        else if (ctrl.hold)
            step_next = step_reg;
        else
            step_next = step_reg + STEP_BITS'(1);
    end

    assign item_ready = ctrl.act == ACT_FETCH;
    assign emit_fire  = ctrl.act == ACT_EMIT && out_free;
    assign div_start  = ctrl.act == ACT_DIV1 || ctrl.act == ACT_DIV2;

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    assign e_ext   = {{(TB-EDGE_BITS){1'b0}}, e_reg};
    assign rev_ext = {{(TB-EDGE_BITS){1'b0}}, rev_reg};
    assign p_ext   = {{(TB-PB){1'b0}}, period_reg};
    assign r1_ext  = {{(TB-PB){1'b0}}, r1_reg};
    assign r2_ext  = {{(TB-PB){1'b0}}, r2_reg};

    assign e_gt = e_ext > phase_reg;
    assign drop = (phase_reg >= rev_ext) || (e_ext < phase_reg);

    assign n1 = e_gt ? e_ext - phase_reg - TB'(1) : '0;
    assign n2 = rev_ext - phase_reg + p_ext - TB'(1);
    assign div_dividend = (ctrl.act == ACT_DIV1) ? n1 : n2;

    fpbs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (period_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // phase after k1 free-run cells, and period correction from the edge offset
    assign phase_mid = e_gt ? e_ext - TB'(1) - r1_ext : phase_reg;
    assign off       = e_gt ? {1'b0, r1_reg} + (PB+1)'(1) : '0;
    assign half      = period_reg >> 1;

    always_comb
    begin
        delta      = $signed({1'b0, off}) - $signed({2'b00, half});
        delta_half = (delta >>> 1) + $signed({{(PB+1){1'b0}}, delta[PB+1] & delta[0]});
        newp_raw   = $signed({2'b00, period_reg}) + delta_half;
        if (newp_raw < $signed((PB+2)'(1)))
            newp_next = PB'(1);
        else if (newp_raw > $signed({2'b00, PERIOD_MAX}))
            newp_next = PERIOD_MAX;
        else
            newp_next = newp_raw[PB-1:0];
    end

    assign over_next       = k2_reg <= k1_reg;
    assign phase_cand_next = over_next ? rev_ext + p_ext - TB'(1) - r2_ext : phase_mid;
    assign add_cnt_next    = over_next ? {1'b0, k2_reg} : {1'b0, k1_reg} + (TB+1)'(1);

    assign bits_sum = {{(TB+2-COUNT_BITS){1'b0}}, bits_reg} + {1'b0, add_cnt_reg};
    assign bits_sat = (bits_sum > (TB+2)'(COUNT_MAX)) ? COUNT_MAX
                                                       : bits_sum[COUNT_BITS-1:0];
    assign bytes_sum = {1'b0, bits_reg} + (COUNT_BITS+1)'(7);

    assign start_period = (nominal_reg == '0) ? PB'(1) : PB'(nominal_reg);

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= ST_FETCH;
            nominal_reg      <= NOMINAL_RESET;
            rev_reg          <= REV_RESET;
            phase_reg        <= '0;
            period_reg       <= PB'(NOMINAL_RESET);
            bits_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_NOMINAL_PERIOD:  nominal_reg <= cfg_data[NOMINAL_BITS-1:0];
                    CFG_REVOLUTION_TIME: rev_reg     <= cfg_data[EDGE_BITS-1:0];
                    default:             ;
                endcase
            end
            if (ctrl.act == ACT_COMMIT)
            begin
                if (over_reg)
                    phase_reg <= phase_cand_reg;
                else
                begin
                    phase_reg  <= phase_cand_reg + {{(TB-PB){1'b0}}, newp_reg};
                    period_reg <= newp_reg;
                end
                bits_reg <= bits_sat;
            end
            else if (ctrl.act == ACT_START)
            begin
                phase_reg  <= '0;
                period_reg <= start_period;
                bits_reg   <= '0;
            end
            if (emit_fire)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.act)
            ACT_FETCH:
            begin
                if (item_valid)
                begin
                    req_reg <= req_type;
                    e_reg   <= (req_type == REQ_END) ? rev_reg : edge_time;
                end
            end
            ACT_ZERO:   zeros_reg <= '0;
            ACT_CAPT1:
            begin
                if (div_done)
                begin
                    k1_reg <= div_quo;
                    r1_reg <= div_rem;
                end
            end
            ACT_CAPT2:
            begin
                if (div_done)
                begin
                    k2_reg <= div_quo;
                    r2_reg <= div_rem;
                end
            end
            ACT_PREP:
            begin
                over_reg       <= over_next;
                newp_reg       <= newp_next;
                phase_cand_reg <= phase_cand_next;
                add_cnt_reg    <= add_cnt_next;
            end
            ACT_COMMIT: zeros_reg <= over_reg ? k2_reg : k1_reg;
            ACT_EMIT:
            begin
                if (out_free)
                begin
                    zero_run_reg    <= zeros_reg[EDGE_BITS-1:0];
                    track_end_reg   <= req_reg == REQ_END;
                    track_bytes_reg <= (req_reg == REQ_END) ? bytes_sum[COUNT_BITS:3] : '0;
                end
            end
            default:    ;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign zero_run     = zero_run_reg;
    assign track_bytes  = track_bytes_reg;
    assign track_end    = track_end_reg;
    assign cfg_ready    = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/core/fpbs_checker.sv -----
// ============================================================================
// fpbs_checker: port-level checks for the bit separator
// Watches the top-level handshakes and result beats over time.
// ============================================================================
`default_nettype none

module fpbs_checker
    import fpbs_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      item_valid,
    input wire logic                      item_ready,
    input wire logic                      result_valid,
    input wire logic                      result_ready,
    input wire logic [EDGE_BITS-1:0]      zero_run,
    input wire logic [BYTES_BITS-1:0]     track_bytes,
    input wire logic                      track_end
);

    // one beat in flight: no item taken right after an accepted one
    a_item_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("item taken on consecutive cycles");

    // byte count only on the end-of-track beat
    a_bytes_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !track_end) |-> (track_bytes == '0))
        else $error("track_bytes nonzero on edge result");

    // a result is produced only while the sequencer is away from fetch
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
        else $error("result appeared while idle at fetch");

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(zero_run) && $stable(track_bytes) &&
             $stable(track_end)))
        else $error("stalled result beat changed");

endmodule

bind flux_pll_bit_separator_top fpbs_checker u_fpbs_checker (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: flux PLL bit separator
// Drives start, edge, end and unknown requests through the item port with
// random gaps, mirrors the phase / period / bit-count tracking in a local
// predictor and checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
    import fpbs_pkg::*;

    localparam longint     PHASE_WRAP   = (longint'(1) << TIME_BITS) - 1;
    localparam longint     EDGE_MAX     = (longint'(1) << EDGE_BITS) - 1;
    localparam longint     PERIOD_LIMIT = longint'(PERIOD_MAX);
    localparam longint     BIT_LIMIT    = longint'(COUNT_MAX);
    localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         SETTLE       = 100;

    typedef struct packed {
        logic [EDGE_BITS-1:0]  zero_run;
        logic [BYTES_BITS-1:0] track_bytes;
        logic                  track_end;
    } track_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_ready;
    logic [1:0]                req_type;
    logic [EDGE_BITS-1:0]      edge_time;
    logic                      result_valid;
    logic                      result_ready;
    logic [EDGE_BITS-1:0]      zero_run;
    logic [BYTES_BITS-1:0]     track_bytes;
    logic                      track_end;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    track_result_t expected_results[$];
    longint        cfg_nominal;
    longint        cfg_revolution;
    longint        model_phase;
    longint        model_cell_ns;
    longint        pll_bits;
    int            error_count;
    int            items_sent;
    int            result_hold;
    bit            no_gaps;

    flux_pll_bit_separator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .req_type     (req_type),
        .edge_time    (edge_time),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .zero_run     (zero_run),
        .track_bytes  (track_bytes),
        .track_end    (track_end),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_period(input longint p);
        if (p < 1)
            return 1;
        if (p > PERIOD_LIMIT)
            return PERIOD_LIMIT;
        return p;
    endfunction

    function automatic void count_bits(input longint n);
        pll_bits = pll_bits + n;
        if (pll_bits > BIT_LIMIT)
            pll_bits = BIT_LIMIT;
    endfunction

    // advance the PLL to an edge; returns 1 when a one bit lands in a window
    function automatic bit pll_advance(input longint edge_ns, output longint zeros);
        longint p;
        longint k1;
        longint k2;
        longint delta;
        p = (model_cell_ns != 0) ? model_cell_ns : 1;
        zeros = 0;
        if (model_phase >= cfg_revolution || edge_ns < model_phase)
            return 0;
        k1 = (edge_ns > model_phase) ? (edge_ns - model_phase - 1) / p : 0;
        k2 = (cfg_revolution - model_phase + p - 1) / p;
        if (k2 <= k1)
        begin
            model_phase = (model_phase + k2 * p) & PHASE_WRAP;
            count_bits(k2);
            zeros = k2;
            return 0;
        end
        model_phase = model_phase + k1 * p;
        delta = edge_ns - (model_phase + p / 2);
        model_cell_ns = clamp_period(p + delta / 2);
        model_phase = (model_phase + model_cell_ns) & PHASE_WRAP;
        count_bits(k1 + 1);
        zeros = k1;
        return 1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // entered and left at a falling edge; valid stays high after the beat
    task automatic send_item(input logic [1:0] kind, input longint edge_ns, input int gap);
        longint zeros;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        req_type   <= kind;
        edge_time  <= EDGE_BITS'(edge_ns);
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        case (kind)
            REQ_START:
            begin
                model_phase   = 0;
                model_cell_ns = clamp_period(cfg_nominal);
                pll_bits      = 0;
            end
            REQ_EDGE:
                if (pll_advance(edge_ns & EDGE_MAX, zeros))
                    expected_results.push_back('{EDGE_BITS'(zeros), BYTES_BITS'(0), 1'b0});
            REQ_END:
            begin
                void'(pll_advance(cfg_revolution, zeros));
                expected_results.push_back('{EDGE_BITS'(zeros),
                                             BYTES_BITS'((pll_bits + 7) / 8), 1'b1});
            end
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic quiesce();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_NOMINAL_PERIOD:  cfg_nominal = value & 64'hFFFF;
            CFG_REVOLUTION_TIME: cfg_revolution = value & EDGE_MAX;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic configure(input longint nominal, input longint revolution);
        quiesce();
        write_reg(CFG_NOMINAL_PERIOD, nominal);
        write_reg(CFG_REVOLUTION_TIME, revolution);
        cfg_valid <= 1'b0;
    endtask

    // one track: mostly plausible ascending edges, with some noise mixed in
    task automatic run_track(input int n_edges);
        longint bit_ns;
        longint t;
        longint jitter;
        int     r;
        bit_ns = (cfg_nominal == 0) ? 1 : cfg_nominal;
        send_item(REQ_START, $urandom_range(0, 32'(EDGE_MAX)), pick_gap());
        t = $urandom_range(0, 32'(bit_ns));
        repeat (n_edges)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                jitter = longint'($urandom_range(0, 32'(bit_ns / 2))) - bit_ns / 4;
                t = t + bit_ns * longint'($urandom_range(2, 4)) + jitter;
                if (t > EDGE_MAX)
                    t = EDGE_MAX;
                if (t < 0)
                    t = 0;
                send_item(REQ_EDGE, t, pick_gap());
            end
            else if (r < 88)
                send_item(REQ_EDGE, $urandom_range(0, 32'(t)), pick_gap());
            else if (r < 94)
                send_item(REQ_EDGE, $urandom_range(0, 32'(EDGE_MAX)), pick_gap());
            else if (r < 97)
                send_item(REQ_UNKNOWN, $urandom_range(0, 32'(EDGE_MAX)), pick_gap());
            else
            begin
                send_item(REQ_START, $urandom_range(0, 32'(EDGE_MAX)), pick_gap());
                t = 0;
            end
        end
        send_item(REQ_END, $urandom_range(0, 32'(EDGE_MAX)), pick_gap());
    endtask

    task automatic run_phase(input longint nominal, input longint revolution, input int n);
        int first;
        configure(nominal, revolution);
        first = items_sent;
        while (items_sent - first < n)
            run_track($urandom_range(4, 30));
    endtask

    task automatic test_reset_defaults();
        send_item(REQ_EDGE, 0, pick_gap());
        send_item(REQ_EDGE, 3500, pick_gap());
        send_item(REQ_EDGE, 100, pick_gap());
        send_item(REQ_UNKNOWN, EDGE_MAX, pick_gap());
        send_item(REQ_EDGE, 28'h5555555, pick_gap());
        send_item(REQ_EDGE, 28'hAAAAAAA, pick_gap());
        send_item(REQ_EDGE, EDGE_MAX, pick_gap());
        send_item(REQ_EDGE, 5000, pick_gap());
        send_item(REQ_END, 0, pick_gap());
        send_item(REQ_START, EDGE_MAX, pick_gap());
        send_item(REQ_END, EDGE_MAX, pick_gap());
    endtask

    task automatic test_config_extremes();
        configure(1, EDGE_MAX);
        send_item(REQ_START, 0, pick_gap());
        send_item(REQ_EDGE, 0, pick_gap());
        send_item(REQ_END, 0, pick_gap());
        configure(PERIOD_LIMIT, 1);
        send_item(REQ_START, 0, pick_gap());
        send_item(REQ_EDGE, 0, pick_gap());
        send_item(REQ_EDGE, 5, pick_gap());
        send_item(REQ_END, 0, pick_gap());
        configure(0, 3000);
        send_item(REQ_START, 0, pick_gap());
        send_item(REQ_EDGE, 2, pick_gap());
        send_item(REQ_END, 0, pick_gap());
    endtask

    task automatic test_random_tracks();
        run_phase(2000, 2000 * longint'($urandom_range(40, 120)), 100);
        run_phase(1, $urandom_range(20, 150), 100);
        run_phase(PERIOD_LIMIT, PERIOD_LIMIT * longint'($urandom_range(20, 100)), 100);
        no_gaps = 1'b1;
        run_phase($urandom_range(1, 65535), $urandom_range(1, 32'(EDGE_MAX)), 90);
        no_gaps = 1'b0;
        run_phase($urandom_range(100, 5000), $urandom_range(3000, 600000), 100);
    endtask

    task automatic test_result_backpressure();
        configure(2000, 4000000);
        no_gaps = 1'b1;
        result_hold = 400;
        run_track(20);
        no_gaps = 1'b0;
    endtask

    initial
    begin
        item_valid     = 1'b0;
        req_type       = REQ_START;
        edge_time      = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_NOMINAL_PERIOD;
        cfg_data       = '0;
        cfg_nominal    = longint'(NOMINAL_RESET);
        cfg_revolution = longint'(REV_RESET);
        model_phase    = 0;
        model_cell_ns  = longint'(NOMINAL_RESET);
        pll_bits       = 0;
        error_count    = 0;
        items_sent     = 0;
        result_hold    = 0;
        no_gaps        = 1'b0;
        rst_n          = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_result_backpressure();
        test_random_tracks();
        quiesce();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : result_sink
        track_result_t want;
        int            stall;
        bit            took;
        result_ready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            took = result_valid && result_ready;
            if (took)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result beat, zero_run", zero_run, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (zero_run !== want.zero_run)
                        report_mismatch("zero_run", zero_run, want.zero_run);
                    if (track_bytes !== want.track_bytes)
                        report_mismatch("track_bytes", track_bytes, want.track_bytes);
                    if (track_end !== want.track_end)
                        report_mismatch("track_end", track_end, want.track_end);
                end
            end
            @(negedge clk);
            if (took)
                stall = pick_gap();
            if (result_hold > 0)
            begin
                result_ready <= 1'b0;
                result_hold--;
            end
            else if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
